// File: hw/rtl/ottt_pkg.sv
// ----------------------------------------------------------------------------
// ottt_pkg
// Shared widths, operation codes, controller states and the command/status
// bundles that pass between the task table controller and its datapath.
// ----------------------------------------------------------------------------
package ottt_pkg;

    // Fixed field widths
    localparam int W_OP     = 3;
    localparam int W_ID     = 16;
    localparam int W_HANDLE = 16;
    localparam int W_SLOT   = 8;
    localparam int W_COUNT  = 5;
    localparam int W_DROP   = 8;
    localparam int W_PCT    = 7;

    // Occupancy is reported in percent; drop count saturates here
    localparam int unsigned   PCT_SCALE = 100;
    localparam logic [W_DROP-1:0] DROP_MAX = 8'hFF;

    // Operation codes (code 7 is undefined and fails)
    typedef enum logic [W_OP-1:0] {
        OP_APPEND     = 3'd0,
        OP_PULL_OWNER = 3'd1,
        OP_PULL_SLOT  = 3'd2,
        OP_PEEK       = 3'd3,
        OP_CLR_HANDLE = 3'd4,
        OP_CLR_RANGE  = 3'd5,
        OP_RELEASE    = 3'd6
    } t_op;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_APPEND,
        S_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_in;      // latch the accepted beat, clear result fields
        logic rd_en;        // read the table
        logic rd_sh;        // read address is shift pointer + 1 (else scan index)
        logic wr_shift;     // write read data one slot toward the head
        logic wr_append;    // write the new task at the tail
        logic occ_inc;
        logic occ_dec;
        logic idx_zero;
        logic idx_slot;
        logic idx_inc;
        logic sh_zero;
        logic sh_from_idx;
        logic sh_inc;
        logic cap_pull;     // capture pulled handle, mark it in use
        logic cap_peek;     // capture peeked owner
        logic set_fail;
        logic in_use_chk;   // drop in-use mark if covered by the range
        logic in_use_clr;
        logic drop_inc;
        logic load_out;     // move results into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic full;
        logic slot_ok;
        logic idx_end;
        logic sh_end;
        logic owner_hit;
        logic handle_hit;
        logic range_hit;
        logic range_bad;
    } t_sts;

endpackage

// File: hw/rtl/ottt_if.sv
// ----------------------------------------------------------------------------
// ottt_in_if / ottt_out_if
// Valid/ready channels for task requests and their results.
// ----------------------------------------------------------------------------
interface ottt_in_if
    import ottt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [W_OP-1:0]     op;
    logic [W_ID-1:0]     owner_id;
    logic [W_HANDLE-1:0] msg_handle;
    logic [W_SLOT-1:0]   slot_index;
    logic [W_HANDLE-1:0] range_start;
    logic [W_HANDLE-1:0] range_end;

    modport source (
        output valid, op, owner_id, msg_handle, slot_index, range_start, range_end,
        input  ready
    );
    modport sink (
        input  valid, op, owner_id, msg_handle, slot_index, range_start, range_end,
        output ready
    );
endinterface

interface ottt_out_if
    import ottt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                status;
    logic [W_HANDLE-1:0] handle_out;
    logic [W_ID-1:0]     owner_out;
    logic [W_COUNT-1:0]  task_count;
    logic [W_DROP-1:0]   drop_total;
    logic [W_PCT-1:0]    peak_percent;

    modport source (
        output valid, status, handle_out, owner_out, task_count, drop_total,
        peak_percent,
        input  ready
    );
    modport sink (
        input  valid, status, handle_out, owner_out, task_count, drop_total,
        peak_percent,
        output ready
    );
endinterface

// File: hw/rtl/owner_tagged_task_table.sv
// ----------------------------------------------------------------------------
// owner_tagged_task_table
// Ordered table of pending tasks (message handle + owner id) with append,
// pull by owner or slot, peek, clear by handle, range clear and release.
// ----------------------------------------------------------------------------
// One request is worked at a time. A request passes through accept, decode
// and result, plus the table walk: a scan visits entries with a read, then
// a compare, and a removal moves each later entry one slot toward the
// head with a read and a write per entry, both through the single read
// and single write port of the table memory. Release and requests refused
// at decode go from decode straight to the result. A new request is taken
// while the previous result still waits in the output register. task_count
// reports the low 5 bits of occupancy.
// ----------------------------------------------------------------------------
module owner_tagged_task_table
    import ottt_pkg::*;
#(
    parameter int TABLE_DEPTH  = 16,
    parameter int BUFFER_BYTES = 2048
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ottt_in_if.sink  i_task,
    ottt_out_if.source o_res
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    ottt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_task.valid),
        .o_in_ready  (i_task.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Table and counters
    ottt_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_op           (i_task.op),
        .i_owner_id     (i_task.owner_id),
        .i_msg_handle   (i_task.msg_handle),
        .i_slot_index   (i_task.slot_index),
        .i_range_start  (i_task.range_start),
        .i_range_end    (i_task.range_end),
        .o_status       (o_res.status),
        .o_handle_out   (o_res.handle_out),
        .o_owner_out    (o_res.owner_out),
        .o_task_count   (o_res.task_count),
        .o_drop_total   (o_res.drop_total),
        .o_peak_percent (o_res.peak_percent)
    );

    // Busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_task.valid && i_task.ready) |=> !i_task.ready)
        else $error("request taken while previous one still in progress");

    // Tail write only when the table has room
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_append |-> !w_sts.full)
        else $error("append written into a full table");

    // Result loaded only into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_res.valid || o_res.ready))
        else $error("result overwrote a beat not yet taken");

endmodule

// File: hw/rtl/ottt_ctrl.sv
// ----------------------------------------------------------------------------
// ottt_ctrl
// Sequencer for the task table: decodes the latched request, walks the
// table for searches, runs the shift-toward-head removal, and hands the
// result to the output register once it is free.
// ----------------------------------------------------------------------------
module ottt_ctrl
    import ottt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_APPEND:     n_state = i_sts.full ? S_SHIFT_RD : S_APPEND;
                    OP_PULL_OWNER: n_state = S_SCAN_RD;
                    OP_PULL_SLOT,
                    OP_PEEK:       n_state = i_sts.slot_ok ? S_SCAN_RD : S_FINISH;
                    OP_CLR_HANDLE: n_state = S_SCAN_RD;
                    OP_CLR_RANGE:  n_state = i_sts.range_bad ? S_FINISH : S_SCAN_RD;
                    default:       n_state = S_FINISH;
                endcase
            end
            S_SCAN_RD: begin
                n_state = i_sts.idx_end ? S_FINISH : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                case (i_sts.op)
                    OP_PULL_OWNER: n_state = i_sts.owner_hit ? S_SHIFT_RD : S_SCAN_RD;
                    OP_PULL_SLOT:  n_state = S_SHIFT_RD;
                    OP_CLR_HANDLE: n_state = i_sts.handle_hit ? S_SHIFT_RD : S_SCAN_RD;
                    OP_CLR_RANGE:  n_state = i_sts.range_hit ? S_SHIFT_RD : S_FINISH;
                    default:       n_state = S_FINISH;
                endcase
            end
            S_SHIFT_RD: begin
                if (!i_sts.sh_end) begin
                    n_state = S_SHIFT_WR;
                end else begin
                    case (i_sts.op)
                        OP_APPEND:     n_state = S_APPEND;
                        OP_PULL_OWNER,
                        OP_PULL_SLOT:  n_state = S_FINISH;
                        default:       n_state = S_SCAN_RD;
                    endcase
                end
            end
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_APPEND:   n_state = S_FINISH;
            S_FINISH: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_in = i_in_valid;
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_APPEND:     o_cmd.sh_zero = i_sts.full;
                    OP_PULL_OWNER: o_cmd.idx_zero = 1'b1;
                    OP_PULL_SLOT,
                    OP_PEEK: begin
                        o_cmd.idx_slot = i_sts.slot_ok;
                        o_cmd.set_fail = !i_sts.slot_ok;
                    end
                    OP_CLR_HANDLE: o_cmd.idx_zero = 1'b1;
                    OP_CLR_RANGE: begin
                        o_cmd.set_fail   = i_sts.range_bad;
                        o_cmd.in_use_chk = !i_sts.range_bad;
                        o_cmd.idx_zero   = !i_sts.range_bad;
                    end
                    OP_RELEASE:    o_cmd.in_use_clr = 1'b1;
                    default:       o_cmd.set_fail = 1'b1;
                endcase
            end
            S_SCAN_RD: begin
                o_cmd.rd_en    = !i_sts.idx_end;
                // owner search ran off the end without a match
                o_cmd.set_fail = i_sts.idx_end && (i_sts.op == OP_PULL_OWNER);
            end
            S_SCAN_CHK: begin
                case (i_sts.op)
                    OP_PULL_OWNER: begin
                        o_cmd.cap_pull    = i_sts.owner_hit;
                        o_cmd.sh_from_idx = i_sts.owner_hit;
                        o_cmd.idx_inc     = !i_sts.owner_hit;
                    end
                    OP_PULL_SLOT: begin
                        o_cmd.cap_pull    = 1'b1;
                        o_cmd.sh_from_idx = 1'b1;
                    end
                    OP_PEEK:       o_cmd.cap_peek = 1'b1;
                    OP_CLR_HANDLE: begin
                        o_cmd.sh_from_idx = i_sts.handle_hit;
                        o_cmd.idx_inc     = !i_sts.handle_hit;
                    end
                    OP_CLR_RANGE: begin
                        o_cmd.sh_from_idx = i_sts.range_hit;
                        o_cmd.drop_inc    = i_sts.range_hit;
                    end
                    default: ;
                endcase
            end
            S_SHIFT_RD: begin
                o_cmd.rd_en   = !i_sts.sh_end;
                o_cmd.rd_sh   = 1'b1;
                o_cmd.occ_dec = i_sts.sh_end;
            end
            S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.sh_inc   = 1'b1;
            end
            S_APPEND: begin
                o_cmd.wr_append = 1'b1;
                o_cmd.occ_inc   = 1'b1;
            end
            S_FINISH: begin
                o_cmd.load_out = w_out_free;
            end
            default: ;
        endcase
    end

endmodule

// File: hw/rtl/ottt_dp.sv
// ----------------------------------------------------------------------------
// ottt_dp
// Task table datapath: the handle/owner memory with a registered read port,
// scan and shift pointers, occupancy, in-use mark, drop and peak counters,
// and the result/output registers.
// ----------------------------------------------------------------------------
module ottt_dp
    import ottt_pkg::*;
#(
    parameter int TABLE_DEPTH  = 16,
    parameter int BUFFER_BYTES = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [W_OP-1:0]     i_op,
    input  logic [W_ID-1:0]     i_owner_id,
    input  logic [W_HANDLE-1:0] i_msg_handle,
    input  logic [W_SLOT-1:0]   i_slot_index,
    input  logic [W_HANDLE-1:0] i_range_start,
    input  logic [W_HANDLE-1:0] i_range_end,
    output logic                o_status,
    output logic [W_HANDLE-1:0] o_handle_out,
    output logic [W_ID-1:0]     o_owner_out,
    output logic [W_COUNT-1:0]  o_task_count,
    output logic [W_DROP-1:0]   o_drop_total,
    output logic [W_PCT-1:0]    o_peak_percent
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);   // counts 0..TABLE_DEPTH
    localparam int AW = $clog2(TABLE_DEPTH);       // table address
    localparam int SW = (CW > W_SLOT) ? CW : W_SLOT;
    localparam int DW = W_HANDLE + W_ID;
    localparam int EW = W_HANDLE + 1;

    // Latched request
    t_op                 r_op;
    logic [W_ID-1:0]     r_owner;
    logic [W_HANDLE-1:0] r_handle;
    logic [W_SLOT-1:0]   r_slot;
    logic [W_HANDLE-1:0] r_rs;
    logic [W_HANDLE-1:0] r_re;

    // Table storage, entry = {handle, owner}
    logic [DW-1:0]       r_mem [TABLE_DEPTH];
    logic [DW-1:0]       r_rdata;
    logic [W_HANDLE-1:0] w_rd_handle;
    logic [W_ID-1:0]     w_rd_owner;
    logic [AW-1:0]       w_rd_addr;
    logic [AW-1:0]       w_wr_addr;
    logic [DW-1:0]       w_wr_data;

    // Pointers and state
    logic [CW-1:0]       r_occ;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_sh;
    logic [CW-1:0]       w_sh_next;
    logic [CW-1:0]       w_occ_inc;
    logic                r_iu_valid;
    logic [W_HANDLE-1:0] r_iu_handle;
    logic                w_iu_hit;
    logic [W_DROP-1:0]   r_drop;
    logic                w_drop_bump;
    logic [W_PCT-1:0]    r_peak;
    logic [W_PCT-1:0]    w_pct_lut [TABLE_DEPTH+1];

    // Per-request results
    logic                r_fail;
    logic [W_HANDLE-1:0] r_hout;
    logic [W_ID-1:0]     r_oout;

    // Occupancy-to-percent table, one entry per fill level
    for (genvar g = 0; g <= TABLE_DEPTH; g++) begin : g_pct
        localparam int unsigned PctVal = (g * PCT_SCALE) / TABLE_DEPTH;
        assign w_pct_lut[g] = W_PCT'(PctVal);
    end

    assign w_rd_handle = r_rdata[DW-1:W_ID];
    assign w_rd_owner  = r_rdata[W_ID-1:0];
    assign w_sh_next   = r_sh + CW'(1);
    assign w_occ_inc   = r_occ + CW'(1);
    assign w_rd_addr   = i_cmd.rd_sh ? w_sh_next[AW-1:0] : r_idx[AW-1:0];
    assign w_wr_addr   = i_cmd.wr_shift ? r_sh[AW-1:0] : r_occ[AW-1:0];
    assign w_wr_data   = i_cmd.wr_shift ? r_rdata : {r_handle, r_owner};
    assign w_iu_hit    = r_iu_valid && (r_iu_handle >= r_rs) && (r_iu_handle <= r_re);
    assign w_drop_bump = i_cmd.drop_inc || (i_cmd.in_use_chk && w_iu_hit);

    // Status back to the controller
    always_comb begin
        o_sts.op         = r_op;
        o_sts.full       = (r_occ >= CW'(TABLE_DEPTH));
        o_sts.slot_ok    = (SW'(r_slot) < SW'(r_occ));
        o_sts.idx_end    = (r_idx >= r_occ);
        o_sts.sh_end     = (w_sh_next >= r_occ);
        o_sts.owner_hit  = (w_rd_owner == r_owner);
        o_sts.handle_hit = (w_rd_handle == r_handle);
        o_sts.range_hit  = (w_rd_handle >= r_rs) && (w_rd_handle <= r_re);
        o_sts.range_bad  = ({1'b0, r_re} > EW'(BUFFER_BYTES - 1));
    end

    // Request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op     <= t_op'(i_op);
            r_owner  <= i_owner_id;
            r_handle <= i_msg_handle;
            r_slot   <= i_slot_index;
            r_rs     <= i_range_start;
            r_re     <= i_range_end;
        end
    end

    // Table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_shift || i_cmd.wr_append) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // Scan index and shift pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_zero) begin
            r_idx <= '0;
        end else if (i_cmd.idx_slot) begin
            r_idx <= CW'(r_slot);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.sh_zero) begin
            r_sh <= '0;
        end else if (i_cmd.sh_from_idx) begin
            r_sh <= r_idx;
        end else if (i_cmd.sh_inc) begin
            r_sh <= w_sh_next;
        end
    end

    // Occupancy and peak percent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_peak <= '0;
        end else if (i_cmd.occ_inc) begin
            r_occ <= w_occ_inc;
            if (w_pct_lut[w_occ_inc] > r_peak) r_peak <= w_pct_lut[w_occ_inc];
        end else if (i_cmd.occ_dec) begin
            r_occ <= r_occ - CW'(1);
        end
    end

    // In-use mark and saturating drop count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iu_valid  <= 1'b0;
            r_iu_handle <= '0;
            r_drop      <= '0;
        end else begin
            if (i_cmd.cap_pull) begin
                r_iu_valid  <= 1'b1;
                r_iu_handle <= w_rd_handle;
            end else if (i_cmd.in_use_clr || (i_cmd.in_use_chk && w_iu_hit)) begin
                r_iu_valid <= 1'b0;
            end
            if (w_drop_bump && (r_drop != DROP_MAX)) begin
                r_drop <= r_drop + W_DROP'(1);
            end
        end
    end

    // Per-request result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_fail <= 1'b0;
            r_hout <= '0;
            r_oout <= '0;
        end else begin
            if (i_cmd.set_fail) r_fail <= 1'b1;
            if (i_cmd.cap_pull) r_hout <= w_rd_handle;
            if (i_cmd.cap_peek) r_oout <= w_rd_owner;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status       <= r_fail;
            o_handle_out   <= r_hout;
            o_owner_out    <= r_oout;
            o_task_count   <= W_COUNT'(r_occ);
            o_drop_total   <= r_drop;
            o_peak_percent <= r_peak;
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the owner-tagged task table. A driver feeds request
// beats from a queue filled up front, and a scoreboard keeps its own copy of
// the table, in-use mark, drop count and peak occupancy. Every accepted
// request yields one predicted result, which is checked field by field
// against the next result beat. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import ottt_pkg::*;

    localparam int DEPTH       = 16;
    localparam int BUF_BYTES   = 2048;
    localparam int RANDOM_REQS = 1500;
    localparam int IDLE_PCT    = 29;
    localparam int CALM_FROM   = 600;    // beats with no idling on either side
    localparam int CALM_TO     = 900;
    // worst request is a clear that empties a full table
    localparam int TAIL_CYCLES = 4 * DEPTH * DEPTH + 100;
    // ~1525 requests, each at its worst case, taken many times over
    localparam longint TIMEOUT_NS = 40_000_000;

    localparam logic [W_OP-1:0] OP_UNDEFINED = 3'd7;

    // traffic mix per block of random requests
    localparam int MIX_BALANCED = 0;
    localparam int MIX_FILL     = 1;
    localparam int MIX_DRAIN    = 2;

    typedef struct {
        logic [W_OP-1:0]     op;
        logic [W_ID-1:0]     owner;
        logic [W_HANDLE-1:0] handle;
        logic [W_SLOT-1:0]   slot;
        logic [W_HANDLE-1:0] lo;
        logic [W_HANDLE-1:0] hi;
        bit                  drain;   // hold off until every result is back
    } t_task_req;

    typedef struct {
        logic                status;
        logic [W_HANDLE-1:0] handle;
        logic [W_ID-1:0]     owner;
        logic [W_COUNT-1:0]  count;
        logic [W_DROP-1:0]   drops;
        logic [W_PCT-1:0]    peak;
    } t_task_res;

    logic i_clk;
    logic i_rst_n;

    ottt_in_if  req_if ();
    ottt_out_if res_if ();

    owner_tagged_task_table #(
        .TABLE_DEPTH  (DEPTH),
        .BUFFER_BYTES (BUF_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_task  (req_if),
        .o_res   (res_if)
    );

    // clock, 4 ns period
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // Scoreboard copy of the table
    // ------------------------------------------------------------------
    logic [W_HANDLE-1:0] tbl_handle [DEPTH];
    logic [W_ID-1:0]     tbl_owner  [DEPTH];
    int unsigned         tbl_fill;
    bit                  mark_valid;
    logic [W_HANDLE-1:0] mark_handle;
    int unsigned         drop_cnt;
    int unsigned         peak_pct;

    t_task_res results_due [$];
    t_task_req req_queue [$];
    t_task_req cur_req;

    int beats_in;
    int beats_out;
    int errors;
    int n_append;
    int n_full_append;
    int n_pull;
    int n_range;
    int n_refused;
    bit in_taken;

    // close the gap left by the entry at pos
    function automatic void tbl_remove(int unsigned pos);
        for (int unsigned k = pos; k + 1 < tbl_fill; k++) begin
            tbl_handle[k] = tbl_handle[k + 1];
            tbl_owner[k]  = tbl_owner[k + 1];
        end
        tbl_fill--;
    endfunction

    function automatic void bump_drops();
        if (drop_cnt < DROP_MAX) drop_cnt++;
    endfunction

    function automatic bit in_range(logic [W_HANDLE-1:0] h, logic [W_HANDLE-1:0] lo,
                                    logic [W_HANDLE-1:0] hi);
        return (h >= lo) && (h <= hi);
    endfunction

    // apply one accepted request and queue the result it must produce
    function automatic void predict_request(t_task_req r);
        t_task_res   res;
        int unsigned pct;
        int unsigned i;
        bit          found;

        res = '{status: 1'b0, handle: '0, owner: '0, count: '0, drops: '0, peak: '0};
        case (r.op)
            OP_APPEND: begin
                n_append++;
                if (tbl_fill >= DEPTH) begin
                    tbl_remove(0);
                    n_full_append++;
                end
                tbl_handle[tbl_fill] = r.handle;
                tbl_owner[tbl_fill]  = r.owner;
                tbl_fill++;
                pct = tbl_fill * PCT_SCALE / DEPTH;
                if (pct > peak_pct) peak_pct = pct;
            end
            OP_PULL_OWNER: begin
                n_pull++;
                found = 1'b0;
                for (i = 0; i < tbl_fill && !found; i++) begin
                    if (tbl_owner[i] == r.owner) begin
                        found       = 1'b1;
                        res.handle  = tbl_handle[i];
                        mark_valid  = 1'b1;
                        mark_handle = tbl_handle[i];
                        tbl_remove(i);
                    end
                end
                res.status = !found;
            end
            OP_PULL_SLOT: begin
                n_pull++;
                if (r.slot < tbl_fill) begin
                    res.handle  = tbl_handle[r.slot];
                    mark_valid  = 1'b1;
                    mark_handle = tbl_handle[r.slot];
                    tbl_remove(r.slot);
                end else begin
                    res.status = 1'b1;
                end
            end
            OP_PEEK: begin
                if (r.slot < tbl_fill) res.owner = tbl_owner[r.slot];
                else res.status = 1'b1;
            end
            OP_CLR_HANDLE: begin
                i = 0;
                while (i < tbl_fill) begin
                    if (tbl_handle[i] == r.handle) tbl_remove(i);
                    else i++;
                end
            end
            OP_CLR_RANGE: begin
                n_range++;
                if (r.hi > BUF_BYTES - 1) begin
                    res.status = 1'b1;
                end else begin
                    // covered in-use mark goes first, then matching head entries
                    if (mark_valid && in_range(mark_handle, r.lo, r.hi)) begin
                        mark_valid = 1'b0;
                        bump_drops();
                    end
                    while (tbl_fill > 0 && in_range(tbl_handle[0], r.lo, r.hi)) begin
                        tbl_remove(0);
                        bump_drops();
                    end
                end
            end
            OP_RELEASE: mark_valid = 1'b0;
            default:    res.status = 1'b1;
        endcase
        if (res.status) n_refused++;
        res.count = tbl_fill[W_COUNT-1:0];
        res.drops = drop_cnt[W_DROP-1:0];
        res.peak  = peak_pct[W_PCT-1:0];
        results_due.push_back(res);
    endfunction

    function automatic void note_error(string what, logic [15:0] got, logic [15:0] want);
        if (errors < 10)
            $display("[%0t] mismatch on %s: got 0x%04h, expected 0x%04h",
                     $realtime, what, got, want);
        errors++;
    endfunction

    function automatic void check_field(string what, logic [15:0] got, logic [15:0] want);
        if (got !== want) note_error(what, got, want);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_task_res want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                beats_out++;
                if (results_due.size() == 0) begin
                    note_error("result beat with nothing pending", res_if.task_count, '0);
                end else begin
                    want = results_due.pop_front();
                    check_field("status",       res_if.status,       want.status);
                    check_field("handle_out",   res_if.handle_out,   want.handle);
                    check_field("owner_out",    res_if.owner_out,    want.owner);
                    check_field("task_count",   res_if.task_count,   want.count);
                    check_field("drop_total",   res_if.drop_total,   want.drops);
                    check_field("peak_percent", res_if.peak_percent, want.peak);
                end
            end
            if (req_if.valid && req_if.ready) begin
                in_taken = 1'b1;
                beats_in++;
                predict_request(cur_req);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: present request beats and result ready at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        bit calm;
        calm = (beats_in >= CALM_FROM) && (beats_in < CALM_TO);
        if (i_rst_n) begin
            // a beat still waiting for ready is held as it is
            if (!req_if.valid || in_taken) begin
                if (req_queue.size() != 0
                    && (calm || $urandom_range(0, 99) >= IDLE_PCT)
                    && !(req_queue[0].drain && results_due.size() != 0)) begin
                    cur_req = req_queue.pop_front();
                    req_if.op          <= cur_req.op;
                    req_if.owner_id    <= cur_req.owner;
                    req_if.msg_handle  <= cur_req.handle;
                    req_if.slot_index  <= cur_req.slot;
                    req_if.range_start <= cur_req.lo;
                    req_if.range_end   <= cur_req.hi;
                    req_if.valid       <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            res_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_req(input logic [W_OP-1:0] op, input logic [15:0] owner,
                           input logic [15:0] handle, input logic [7:0] slot,
                           input logic [15:0] lo, input logic [15:0] hi,
                           input bit drain = 1'b0);
        t_task_req r;
        r = '{op: op, owner: owner, handle: handle, slot: slot, lo: lo, hi: hi,
              drain: drain};
        req_queue.push_back(r);
    endtask

    // few owners so pulls by owner find matches
    function automatic logic [15:0] rand_owner();
        int k;
        k = $urandom_range(0, 99);
        if (k < 80) return 16'($urandom_range(0, 5));
        if (k < 85) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // handles on a coarse grid inside the buffer so clears hit
    function automatic logic [15:0] rand_handle();
        if ($urandom_range(0, 99) < 75) return 16'($urandom_range(0, 63) * 32);
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] rand_slot();
        if ($urandom_range(0, 99) < 70) return 8'($urandom_range(0, DEPTH + 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [W_OP-1:0] pick_op(int mix);
        int r;
        r = $urandom_range(0, 99);
        if (mix == MIX_FILL && r < 60) return OP_APPEND;
        if (mix == MIX_DRAIN && r < 55) begin
            case ($urandom_range(0, 3))
                0:       return OP_PULL_OWNER;
                1:       return OP_PULL_SLOT;
                2:       return OP_CLR_HANDLE;
                default: return OP_CLR_RANGE;
            endcase
        end
        r = $urandom_range(0, 99);
        if (r < 30) return OP_APPEND;
        if (r < 45) return OP_PULL_OWNER;
        if (r < 57) return OP_PULL_SLOT;
        if (r < 69) return OP_PEEK;
        if (r < 79) return OP_CLR_HANDLE;
        if (r < 92) return OP_CLR_RANGE;
        if (r < 97) return OP_RELEASE;
        return OP_UNDEFINED;
    endfunction

    task automatic add_random_req(input int mix, input bit drain);
        logic [15:0] lo;
        logic [15:0] hi;
        int          k;
        k = $urandom_range(0, 99);
        if (k < 15) begin
            lo = '0;
            hi = 16'(BUF_BYTES - 1);
        end else if (k < 65) begin
            lo = 16'($urandom_range(0, BUF_BYTES - 1));
            hi = 16'(lo + $urandom_range(0, 512));
            if (hi > BUF_BYTES - 1) hi = 16'(BUF_BYTES - 1);
        end else if (k < 75) begin
            lo = 16'($urandom);
            hi = 16'($urandom_range(BUF_BYTES, 16'hFFFF));
        end else if (k < 85) begin
            hi = 16'($urandom_range(0, BUF_BYTES - 2));
            lo = 16'($urandom_range(hi + 1, BUF_BYTES - 1));
        end else begin
            lo = 16'($urandom);
            hi = 16'($urandom);
        end
        add_req(pick_op(mix), rand_owner(), rand_handle(), rand_slot(), lo, hi, drain);
    endtask

    initial begin
        int made;
        int len;
        int mix;

        req_if.valid       = 1'b0;
        req_if.op          = OP_APPEND;
        req_if.owner_id    = '0;
        req_if.msg_handle  = '0;
        req_if.slot_index  = '0;
        req_if.range_start = '0;
        req_if.range_end   = '0;
        res_if.ready       = 1'b0;
        i_rst_n            = 1'b0;
        beats_in = 0;
        beats_out = 0;
        errors = 0;
        n_append = 0;
        n_full_append = 0;
        n_pull = 0;
        n_range = 0;
        n_refused = 0;
        in_taken = 1'b0;
        tbl_fill = 0;
        mark_valid = 1'b0;
        mark_handle = '0;
        drop_cnt = 0;
        peak_pct = 0;

        // directed: field extremes, every op, each corner
        add_req(OP_APPEND,     16'h0000, 16'h0000, 8'd0,   16'd0,   16'd0);
        add_req(OP_APPEND,     16'hFFFF, 16'hFFFF, 8'd0,   16'd0,   16'd0);
        add_req(OP_APPEND,     16'd3,    16'd2047, 8'd0,   16'd0,   16'd0);
        add_req(OP_APPEND,     16'd3,    16'd64,   8'd0,   16'd0,   16'd0);
        add_req(OP_PEEK,       16'd0,    16'd0,    8'd1,   16'd0,   16'd0);
        add_req(OP_PEEK,       16'd0,    16'd0,    8'd255, 16'd0,   16'd0);
        add_req(OP_PULL_OWNER, 16'd3,    16'd0,    8'd0,   16'd0,   16'd0);
        add_req(OP_PULL_OWNER, 16'h1234, 16'd0,    8'd0,   16'd0,   16'd0);
        add_req(OP_PULL_SLOT,  16'd0,    16'd0,    8'd2,   16'd0,   16'd0);
        add_req(OP_PULL_SLOT,  16'd0,    16'd0,    8'd200, 16'd0,   16'd0);
        add_req(OP_CLR_HANDLE, 16'd0,    16'h5555, 8'd0,   16'd0,   16'd0);
        add_req(OP_APPEND,     16'd1,    16'd0,    8'd0,   16'd0,   16'd0);
        add_req(OP_CLR_HANDLE, 16'd0,    16'd0,    8'd0,   16'd0,   16'd0);
        add_req(OP_APPEND,     16'd2,    16'd100,  8'd0,   16'd0,   16'd0);
        add_req(OP_PULL_SLOT,  16'd0,    16'd0,    8'd1,   16'd0,   16'd0);
        add_req(OP_CLR_RANGE,  16'd0,    16'd0,    8'd0,   16'd0,   16'd2047);
        add_req(OP_CLR_RANGE,  16'd0,    16'd0,    8'd0,   16'd0,   16'd2048);
        add_req(OP_CLR_RANGE,  16'd0,    16'd0,    8'd0,   16'd0,   16'hFFFF);
        add_req(OP_CLR_RANGE,  16'd0,    16'd0,    8'd0,   16'd500, 16'd100);
        add_req(OP_RELEASE,    16'd0,    16'd0,    8'd0,   16'd0,   16'd0);
        add_req(OP_UNDEFINED,  16'd0,    16'd0,    8'd0,   16'd0,   16'd0);
        add_req(OP_PULL_SLOT,  16'd0,    16'd0,    8'd0,   16'd0,   16'd0);
        add_req(OP_PEEK,       16'd0,    16'd0,    8'd0,   16'd0,   16'd0);
        add_req(OP_PULL_OWNER, 16'hFFFF, 16'd0,    8'd0,   16'd0,   16'd0);

        // random blocks, each with its own traffic mix; some open after a full drain
        made = 0;
        while (made < RANDOM_REQS) begin
            mix = $urandom_range(MIX_BALANCED, MIX_DRAIN);
            len = $urandom_range(20, 60);
            for (int n = 0; n < len; n++)
                add_random_req(mix, n == 0 && (made == 0 || $urandom_range(0, 3) == 0));
            made += len;
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // everything sent and answered, then let any stray beat show up
        while (req_queue.size() != 0 || req_if.valid || results_due.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Run covered %0d requests: %0d appends (%0d into a full table), %0d pulls,",
                 beats_in, n_append, n_full_append, n_pull);
        $display("%0d range clears, %0d refused; %0d results checked, drops at %0d, peak %0d%%",
                 n_range, n_refused, beats_out, drop_cnt, peak_pct);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches in total", errors);
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d requests queued and %0d results pending",
                 req_queue.size(), results_due.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
